FILE: src/xcg_pkg.sv
`timescale 1ns / 1ps

package xcg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned SKIP_W = 16;

  localparam logic [1:0] VAR_8  = 2'd0;
  localparam logic [1:0] VAR_16 = 2'd1;
  localparam logic [1:0] VAR_32 = 2'd2;

  localparam logic [1:0] KIND_SEED   = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_GEN    = 2'd2;

  localparam logic [1:0] CFG_VARIANT   = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH = 2'd1;
  localparam logic [1:0] CFG_FALLBACK  = 2'd2;

  localparam logic [1:0]        VARIANT_RST   = VAR_32;
  localparam logic [7:0]        ROW_WIDTH_RST = 8'd26;
  localparam logic [WORD_W-1:0] FALLBACK_RST  = 32'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_EMIT
  } xcg_state_t;

  function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                   input logic [1:0] v);
    unique case (v)
      VAR_8:   mask_word = {24'd0, w[7:0]};
      VAR_16:  mask_word = {16'd0, w[15:0]};
      default: mask_word = w;
    endcase
  endfunction

  // base64 alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    priority if (idx < 6'd26) begin
      b64_char = 8'd65 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      b64_char = 8'd71 + {2'b00, idx};
    end else if (idx < 6'd62) begin
      b64_char = {2'b00, idx} - 8'd4;
    end else if (idx == 6'd62) begin
      b64_char = 8'd43;
    end else begin
      b64_char = 8'd47;
    end
  endfunction

endpackage

FILE: src/xcg_step.sv
`timescale 1ns / 1ps

module xcg_step (
  input  logic [xcg_pkg::WORD_W-1:0] word_i,
  input  logic [1:0]                 variant_i,
  output logic [xcg_pkg::WORD_W-1:0] word_o
);

  always_comb begin
    logic [7:0]  x8;
    logic [15:0] x16;
    logic [31:0] x32;
    x8  = word_i[7:0];
    x16 = word_i[15:0];
    x32 = word_i;
    x8  = x8 ^ (x8 << 7);
    x8  = x8 ^ (x8 >> 5);
    x8  = x8 ^ (x8 << 3);
    x16 = x16 ^ (x16 << 13);
    x16 = x16 ^ (x16 >> 9);
    x16 = x16 ^ (x16 << 7);
    x32 = x32 ^ (x32 << 13);
    x32 = x32 ^ (x32 >> 17);
    x32 = x32 ^ (x32 << 5);
    unique case (variant_i)
      xcg_pkg::VAR_8:  word_o = {24'd0, x8};
      xcg_pkg::VAR_16: word_o = {16'd0, x16};
      default:         word_o = x32;
    endcase
  end

endmodule

FILE: src/xorshift_code_generator_core.sv
`timescale 1ns / 1ps
// A seed or offset word is absorbed in its accept cycle; the input stays ready after it.
// Generate word: after the accept, skip (row*row_width+col, or none with use_offset) steps in
// the skip state, then one step per character in the emit state (none when length is zero),
// one xorshift step per cycle through the single shared step unit; output stalls hold emit.
// Throughput: one word per cycle for characters while idle; input waits out a generate word.
// Reset (rst_n low, synchronous): idle, generator and seed cleared, registers to defaults.

module xorshift_code_generator_core #(
  parameter int unsigned MAX_CODE_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_value, row, col, code_length, use_offset
  input  logic [2:0]  in_tuser,   // kind, first
  input  logic        in_tlast,   // last

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // code_char
  output logic        out_tlast   // last_char
);

  localparam int unsigned W  = xcg_pkg::WORD_W;
  localparam int unsigned LW = xcg_pkg::LEN_W;
  localparam int unsigned SW = xcg_pkg::SKIP_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_CODE_LEN);

  xcg_pkg::xcg_state_t state_r, state_nxt;

  logic [1:0]    variant_r;
  logic [7:0]    row_width_r;
  logic [W-1:0]  fallback_r;
  logic [W-1:0]  gen_r, gen_nxt;
  logic [W-1:0]  seed_r, seed_nxt;
  logic [SW-1:0] skip_r, skip_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic [1:0]    in_kind;
  logic          in_first;
  logic [7:0]    in_char;
  logic [7:0]    in_row;
  logic [7:0]    in_col;
  logic [LW-1:0] in_len;
  logic          in_use_offset;

  logic          in_fire;
  logic          out_free;
  logic          skip_go;
  logic          emit_go;
  logic          char_in;
  logic [W-1:0]  char_base;
  logic [W-1:0]  step_in;
  logic [W-1:0]  step_out;
  logic [W-1:0]  commit;
  logic [SW-1:0] skip_calc;
  logic [LW-1:0] len_sat;

  assign in_kind       = in_tuser[1:0];
  assign in_first      = in_tuser[2];
  assign in_char       = in_tdata[7:0];
  assign in_row        = in_tdata[15:8];
  assign in_col        = in_tdata[23:16];
  assign in_len        = in_tdata[30:24];
  assign in_use_offset = in_tdata[31];

  assign in_tready  = (state_r == xcg_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign skip_go    = (state_r == xcg_pkg::ST_SKIP) && (skip_r != '0);
  assign emit_go    = (state_r == xcg_pkg::ST_EMIT) && (cnt_r != '0) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign char_in = in_fire &&
                   ((in_kind == xcg_pkg::KIND_SEED) || (in_kind == xcg_pkg::KIND_OFFSET));

  always_comb begin
    if (in_kind == xcg_pkg::KIND_SEED) begin
      char_base = in_first ? '0 : gen_r;
    end else begin
      char_base = in_first ? xcg_pkg::mask_word(seed_r, variant_r) : gen_r;
    end
  end

  assign step_in = char_in ? (char_base + {24'd0, in_char}) : gen_r;

  xcg_step u_step (
    .word_i    (step_in),
    .variant_i (variant_r),
    .word_o    (step_out)
  );

  assign commit    = (step_out == '0) ? xcg_pkg::mask_word(fallback_r, variant_r) : step_out;
  assign skip_calc = ({8'd0, in_row} * {8'd0, row_width_r}) + {8'd0, in_col};
  assign len_sat   = (in_len > MAX_LEN) ? MAX_LEN : in_len;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      xcg_pkg::ST_IDLE: begin
        if (in_fire && (in_kind == xcg_pkg::KIND_GEN)) state_nxt = xcg_pkg::ST_SKIP;
      end
      xcg_pkg::ST_SKIP: begin
        if (skip_r == '0) state_nxt = xcg_pkg::ST_EMIT;
      end
      xcg_pkg::ST_EMIT: begin
        if ((cnt_r == '0) || (emit_go && (cnt_r == LW'(1)))) state_nxt = xcg_pkg::ST_IDLE;
      end
      default: state_nxt = xcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    gen_nxt       = gen_r;
    seed_nxt      = seed_r;
    skip_nxt      = skip_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (in_fire) begin
      unique case (in_kind)
        xcg_pkg::KIND_SEED: begin
          gen_nxt = step_out;
          if (in_tlast) begin
            seed_nxt = commit;
            gen_nxt  = xcg_pkg::mask_word(commit, variant_r);
          end
        end
        xcg_pkg::KIND_OFFSET: begin
          gen_nxt = step_out;
        end
        xcg_pkg::KIND_GEN: begin
          cnt_nxt = len_sat;
          if (!in_use_offset) begin
            gen_nxt  = xcg_pkg::mask_word(seed_r, variant_r);
            skip_nxt = skip_calc;
          end else begin
            skip_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (skip_go) begin
      gen_nxt  = step_out;
      skip_nxt = skip_r - SW'(1);
    end
    if (emit_go) begin
      gen_nxt       = step_out;
      out_valid_nxt = 1'b1;
      out_data_nxt  = xcg_pkg::b64_char(step_out[5:0]);
      out_last_nxt  = (cnt_r == LW'(1));
      cnt_nxt       = cnt_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xcg_pkg::ST_IDLE;
      variant_r   <= xcg_pkg::VARIANT_RST;
      row_width_r <= xcg_pkg::ROW_WIDTH_RST;
      fallback_r  <= xcg_pkg::FALLBACK_RST;
      gen_r       <= '0;
      seed_r      <= '0;
      skip_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      seed_r      <= seed_nxt;
      skip_r      <= skip_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          xcg_pkg::CFG_VARIANT:   variant_r   <= cfg_wdata[1:0];
          xcg_pkg::CFG_ROW_WIDTH: row_width_r <= cfg_wdata[7:0];
          xcg_pkg::CFG_FALLBACK:  fallback_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  a_gen_to_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_kind == xcg_pkg::KIND_GEN) |=> state_r == xcg_pkg::ST_SKIP)
    else $error("generate word did not enter skip");

  a_skip_dec: assert property (@(posedge clk) disable iff (!rst_n)
    skip_go |=> skip_r == $past(skip_r) - SW'(1))
    else $error("skip count not decremented");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && (cnt_r == LW'(1)) |=> (state_r == xcg_pkg::ST_IDLE) && out_valid_r && out_last_r)
    else $error("final char did not close the run");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xcg_pkg::ST_EMIT |-> cnt_r <= MAX_LEN)
    else $error("char count above limit");

endmodule
